@@ rtl/nir_pkg.sv @@
// Package for the NEC infrared pulse decoder.
// Holds shared widths, codes, frame constants and the pulse class type.
// No dependencies.
package nir_pkg;

  // Field widths
  localparam int unsigned DurW   = 20;
  localparam int unsigned CntW   = 7;
  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 16;
  localparam int unsigned CmdW   = 32;
  localparam int unsigned CfgIdxW = 3;

  // Number of edges in one full data frame.
  localparam int unsigned FRAME_EDGES = 66;

  // Reset values of the configuration registers
  localparam logic [DurW-1:0] TimeoutReset = DurW'(10000);
  localparam logic [DurW-1:0] LeadReset    = DurW'(6750);
  localparam logic [DurW-1:0] SpaceReset   = DurW'(3375);
  localparam logic [DurW-1:0] RepeatReset  = DurW'(1406);
  localparam logic [DurW-1:0] OneReset     = DurW'(1125);

  // Data store contents and command value reported on a repeat code
  localparam logic [DataW-1:0] RepeatStore = 32'hFFFF_0000;
  localparam logic [CmdW-1:0]  RepeatCmd   = 32'hFFFF_FFFF;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIMEOUT = 3'd0,
    CFG_LEAD    = 3'd1,
    CFG_SPACE   = 3'd2,
    CFG_REPEAT  = 3'd3,
    CFG_ONE     = 3'd4,
    CFG_REP_EN  = 3'd5
  } cfg_idx_e;

  // Result event codes
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_FRAME  = 2'd1,
    EV_REPEAT = 2'd2
  } event_e;

  // Outcome of comparing one duration against the thresholds
  typedef struct packed {
    logic timeout;
    logic over_lead;
    logic over_space;
    logic over_repeat;  // already qualified by the repeat enable
    logic over_one;
  } pulse_class_t;

endpackage

@@ rtl/nir_if.sv @@
// Valid/ready channel interfaces for the NEC infrared pulse decoder.
// Depends on nir_pkg for field widths.
interface nir_in_if
  import nir_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [DurW-1:0] pulse_length;

  modport source (output valid, output pulse_length, input ready);
  modport sink   (input valid, input pulse_length, output ready);
endinterface

interface nir_out_if
  import nir_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [1:0]       event_res;
  logic [AddrW-1:0] address;
  logic [CmdW-1:0]  command;

  modport source (output valid, output event_res, output address, output command,
                  input ready);
  modport sink   (input valid, input event_res, input address, input command,
                  output ready);
endinterface

@@ rtl/nir_front.sv @@
// Front end: configuration registers and classification of each duration.
// Depends on nir_pkg and nir_in_if; feeds nir_queue.
module nir_front
  import nir_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DurW-1:0]    cfg_wdata_i,
  nir_in_if.sink             in_i,
  input  logic               q_ready_i,
  output logic               push_o,
  output pulse_class_t       class_o
);

  logic [DurW-1:0] timeout_q, lead_q, space_q, repeat_q, one_q;
  logic            rep_en_q;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
      lead_q    <= LeadReset;
      space_q   <= SpaceReset;
      repeat_q  <= RepeatReset;
      one_q     <= OneReset;
      rep_en_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TIMEOUT: timeout_q <= cfg_wdata_i;
        CFG_LEAD:    lead_q    <= cfg_wdata_i;
        CFG_SPACE:   space_q   <= cfg_wdata_i;
        CFG_REPEAT:  repeat_q  <= cfg_wdata_i;
        CFG_ONE:     one_q     <= cfg_wdata_i;
        CFG_REP_EN:  rep_en_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // A request is taken whenever the queue has room.
  assign in_i.ready = q_ready_i;
  assign push_o     = in_i.valid && q_ready_i;

  // Compare the duration against every threshold in parallel.
  always_comb begin
    class_o.timeout     = (in_i.pulse_length >= timeout_q);
    class_o.over_lead   = (in_i.pulse_length > lead_q);
    class_o.over_space  = (in_i.pulse_length > space_q);
    class_o.over_repeat = rep_en_q && (in_i.pulse_length > repeat_q);
    class_o.over_one    = (in_i.pulse_length > one_q);
  end

endmodule

@@ rtl/nir_queue.sv @@
// Two-entry queue of classified pulses between front and back end.
// Depends on nir_pkg for the pulse class type.
module nir_queue
  import nir_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  pulse_class_t push_data_i,
  output logic         ready_o,
  input  logic         pop_i,
  output logic         valid_o,
  output pulse_class_t data_o
);

  pulse_class_t mem_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   count_q;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

@@ rtl/nir_back.sv @@
// Back end: frame state machine over the edge count and data store,
// plus the output register. Depends on nir_pkg and nir_out_if.
module nir_back
  import nir_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         q_valid_i,
  input  pulse_class_t q_data_i,
  output logic         pop_o,
  nir_out_if.source    out_o
);

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DataW-1:0] data_q, data_d;
  logic             out_valid_q;
  event_e           ev_q, ev_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [CmdW-1:0]  cmd_q, cmd_d;
  logic [CntW-2:0]  pos;
  logic [4:0]       bit_idx;

  // Take the next pulse when the output register is free or being drained.
  assign pop_o = q_valid_i && (!out_valid_q || out_o.ready);

  // Bit position within the frame; bits run MSB first inside each byte.
  assign pos     = cnt_q[CntW-1:1] - (CntW-1)'(1);
  assign bit_idx = {pos[4:3], ~pos[2:0]};

  // Next frame state and result for the pulse at the queue head.
  always_comb begin
    cnt_d  = cnt_q;
    data_d = data_q;
    ev_d   = EV_NONE;
    addr_d = '0;
    cmd_d  = '0;
    priority if (q_data_i.timeout) begin
      cnt_d = '0;
    end else if (cnt_q == '0) begin
      cnt_d = q_data_i.over_lead ? CntW'(1) : '0;
    end else if (cnt_q == CntW'(1)) begin
      priority if (q_data_i.over_space) begin
        cnt_d = CntW'(2);
      end else if (q_data_i.over_repeat) begin
        data_d = RepeatStore;
        cnt_d  = '0;
        ev_d   = EV_REPEAT;
        cmd_d  = RepeatCmd;
      end else begin
        cnt_d = '0;
      end
    end else if (cnt_q[0]) begin
      // Data edge; positions beyond the store are dropped.
      if (!pos[CntW-2]) begin
        data_d[bit_idx] = q_data_i.over_one;
      end
      cnt_d = cnt_q + CntW'(1);
    end else begin
      cnt_d = cnt_q + CntW'(1);
    end

    // Frame end: accept when byte 2 is the inverse of byte 3.
    if (ev_d == EV_NONE && cnt_d >= CntW'(FRAME_EDGES)) begin
      if (data_d[23:16] == ~data_d[31:24]) begin
        ev_d   = EV_FRAME;
        addr_d = data_d[15:0];
        cmd_d  = {16'h0000, data_d[31:16]};
      end
      cnt_d = '0;
    end
  end

  // Frame state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      data_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      cnt_q       <= cnt_d;
      data_q      <= data_d;
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ev_q   <= ev_d;
      addr_q <= addr_d;
      cmd_q  <= cmd_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.event_res = ev_q;
  assign out_o.address   = addr_q;
  assign out_o.command   = cmd_q;

endmodule

@@ rtl/nec_ir_pulse_decoder.sv @@
// NEC infrared pulse decoder: takes one measured edge duration per request and
// returns exactly one result per request (no event, a checked frame, or a repeat
// code). One duration is accepted every clock cycle while the queue has room;
// an accepted request is stored in the two-entry queue between the threshold
// comparators and the frame state machine, which then loads the output register
// as the request leaves the queue.
// Either side may stall; configuration must be written only while idle.
// Top level: instantiates nir_front, nir_queue and nir_back; depends on nir_pkg
// and the channel interfaces in nir_if.
module nec_ir_pulse_decoder
  import nir_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DurW-1:0]    cfg_wdata_i,
  nir_in_if.sink             in_i,
  nir_out_if.source          out_o
);

  logic         push, q_ready, q_valid, pop;
  pulse_class_t push_class, head_class;

  // Threshold comparison and configuration
  nir_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_i),
    .q_ready_i  (q_ready),
    .push_o     (push),
    .class_o    (push_class)
  );

  // Decoupling queue
  nir_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_class),
    .ready_o    (q_ready),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .data_o     (head_class)
  );

  // Frame decoding and result register
  nir_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_data_i (head_class),
    .pop_o    (pop),
    .out_o    (out_o)
  );

  // A request taken into an empty queue is waiting at the head next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !q_valid) |=> q_valid)
    else $error("accepted request lost in queue");

  // Results with no event carry a zero payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.event_res == EV_NONE) |->
      (out_o.address == '0 && out_o.command == '0))
    else $error("empty result with nonzero payload");

  // A repeat code reports zero address and all-ones command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.event_res == EV_REPEAT) |->
      (out_o.address == '0 && out_o.command == RepeatCmd))
    else $error("repeat code with wrong payload");

  // A decoded frame has its command byte equal to the inverse of the next byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.event_res == EV_FRAME) |->
      (out_o.command[7:0] == ~out_o.command[15:8] && out_o.command[31:16] == '0))
    else $error("frame result fails inverse check");

endmodule
